>>> rtl/core/sctaylor_pkg.sv
// Shared constants, divisor and reciprocal tables and the saturation helper
// for the sine/cosine Taylor core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sctaylor_pkg;

   // Series length and halving limit
   localparam int SERIES_TERMS = 6;
   localparam int MAX_HALVINGS = 7;

   // Field widths
   localparam int ANGLE_W  = 32;
   localparam int RESULT_W = 32;

   // Internal widths
   localparam int MAG_W  = ANGLE_W + 6;                  // |angle| in Q.30, up to 2^37
   localparam int CMP_W  = (MAG_W > 31 + MAX_HALVINGS) ? MAG_W : 31 + MAX_HALVINGS;
   localparam int MUL_W  = 33;                           // shared multiplier operand width
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 36;                           // wide series sums
   localparam int K_W    = $clog2(MAX_HALVINGS + 1);
   localparam int TERM_W = $clog2(SERIES_TERMS);

   // Q2.30 constants
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
   localparam logic [30:0] Q30_MAX_MAG = 31'h7FFF_FFFF;

   // Series divisor for term idx: sine (2i)(2i+1), cosine (2i-1)(2i)
   function automatic logic [7:0] term_divisor(input logic cos_sel, input logic [2:0] idx);
      logic [7:0] d;
      unique case ({cos_sel, idx})
         4'b0_001: d = 8'd6;
         4'b0_010: d = 8'd20;
         4'b0_011: d = 8'd42;
         4'b0_100: d = 8'd72;
         4'b0_101: d = 8'd110;
         4'b0_110: d = 8'd156;
         4'b0_111: d = 8'd210;
         4'b1_001: d = 8'd2;
         4'b1_010: d = 8'd12;
         4'b1_011: d = 8'd30;
         4'b1_100: d = 8'd56;
         4'b1_101: d = 8'd90;
         4'b1_110: d = 8'd132;
         4'b1_111: d = 8'd182;
         default:  d = 8'd1;
      endcase
      return d;
   endfunction

   // Reciprocal floor(2^S / d) with S = 32 + ceil(log2 d)
   function automatic logic [32:0] recip_mult(input logic cos_sel, input logic [2:0] idx);
      logic [32:0] m;
      unique case ({cos_sel, idx})
         4'b0_001: m = 33'd5726623061;
         4'b0_010: m = 33'd6871947673;
         4'b0_011: m = 33'd6544712070;
         4'b0_100: m = 33'd7635497415;
         4'b0_101: m = 33'd4997780126;
         4'b0_110: m = 33'd7048151460;
         4'b0_111: m = 33'd5235769656;
         4'b1_001: m = 33'd4294967296;
         4'b1_010: m = 33'd5726623061;
         4'b1_011: m = 33'd4581298449;
         4'b1_100: m = 33'd4908534052;
         4'b1_101: m = 33'd6108397932;
         4'b1_110: m = 33'd8329633543;
         4'b1_111: m = 33'd6041272680;
         default:  m = 33'd0;
      endcase
      return m;
   endfunction

   // Shift S that goes with the reciprocal above
   function automatic logic [5:0] recip_shift(input logic cos_sel, input logic [2:0] idx);
      logic [5:0] s;
      unique case ({cos_sel, idx})
         4'b0_001: s = 6'd35;
         4'b0_010: s = 6'd37;
         4'b0_011: s = 6'd38;
         4'b0_100: s = 6'd39;
         4'b0_101: s = 6'd39;
         4'b0_110: s = 6'd40;
         4'b0_111: s = 6'd40;
         4'b1_001: s = 6'd33;
         4'b1_010: s = 6'd36;
         4'b1_011: s = 6'd37;
         4'b1_100: s = 6'd38;
         4'b1_101: s = 6'd39;
         4'b1_110: s = 6'd40;
         4'b1_111: s = 6'd40;
         default:  s = 6'd32;
      endcase
      return s;
   endfunction

   // Saturate a wide signed value to Q2.30
   function automatic logic signed [RESULT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = $signed({{(ACC_W-RESULT_W){1'b0}}, 1'b0, {(RESULT_W-1){1'b1}}});
      lo = $signed({{(ACC_W-RESULT_W){1'b1}}, 1'b1, {(RESULT_W-1){1'b0}}});
      if (v > hi) begin
         return hi[RESULT_W-1:0];
      end else if (v < lo) begin
         return lo[RESULT_W-1:0];
      end else begin
         return v[RESULT_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/sine_cosine_taylor_halving_core.sv
// Top level of the sine/cosine core: sequencer around one shared multiplier.
// Depends on sctaylor_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One angle (Q8.24 radians) in, sine and cosine (Q2.30, saturated) out. The angle
// is halved k times (0..7, one compare per cycle) until it lies within pi/2, six
// Taylor terms of sine and of cosine are summed, and k double-angle steps undo the
// halvings. All products go through one 33x33 multiplier: each series term is a
// product, a reciprocal multiply for the factorial divide and a correction, and
// each double-angle step forms s*c, c*c and s*s and then updates both values. The
// input is not ready while an angle is in flight. A finished result waits in the
// output register while the next angle is accepted.
module sine_cosine_taylor_halving_core
   import sctaylor_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [ANGLE_W-1:0]  req_angle,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [RESULT_W-1:0]      rsp_sine_value,
   output logic signed [RESULT_W-1:0]      rsp_cosine_value
);

   // Sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_HALVE = 4'd1;
   localparam logic [3:0] ST_SQ    = 4'd2;
   localparam logic [3:0] ST_SINIT = 4'd3;
   localparam logic [3:0] ST_TMUL  = 4'd4;
   localparam logic [3:0] ST_TRCP  = 4'd5;
   localparam logic [3:0] ST_TFIX  = 4'd6;
   localparam logic [3:0] ST_DSC   = 4'd7;
   localparam logic [3:0] ST_DCC   = 4'd8;
   localparam logic [3:0] ST_DSS   = 4'd9;
   localparam logic [3:0] ST_DUPD  = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   logic [3:0]                  state_ff, state_in;
   logic                        neg_ff, neg_in;
   logic [MAG_W-1:0]            mag_ff, mag_in;
   logic [K_W-1:0]              k_ff, k_in;
   logic [30:0]                 xmag_ff, xmag_in;
   logic [31:0]                 x2_ff, x2_in;
   logic [31:0]                 tmag_ff, tmag_in;
   logic                        tneg_ff, tneg_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic [TERM_W-1:0]           term_ff, term_in;
   logic                        cos_sel_ff, cos_sel_in;
   logic [31:0]                 p_ff, p_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic signed [RESULT_W-1:0]  s_ff, s_in;
   logic signed [RESULT_W-1:0]  c_ff, c_in;
   logic signed [33:0]          sc_ff, sc_in;
   logic [32:0]                 cc_ff, cc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_W-1:0]  rsp_sine_ff, rsp_sine_in;
   logic signed [RESULT_W-1:0]  rsp_cosine_ff, rsp_cosine_in;

   // Shared multiplier operands
   logic [MUL_W-1:0]            mul_a, mul_b;

   // Datapath helpers
   logic [31:0]                 angle_abs;
   logic [CMP_W-1:0]            mag_ext, halve_limit;
   logic                        halve_go;
   logic [MAG_W-1:0]            mag_shr;
   logic [30:0]                 xmag_next;
   logic [2:0]                  tbl_idx;
   logic [7:0]                  div_val;
   logic [PROD_W-1:0]           prod_shr;
   logic [31:0]                 q0, q_fix, rem;
   logic [39:0]                 q0_times_d;
   logic signed [ACC_W-1:0]     t_val, sum_val;
   logic signed [RESULT_W-1:0]  sum_sat;
   logic [32:0]                 s_abs, c_abs;
   logic [32:0]                 prod_q30;
   logic                        sc_neg;

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sine_value   = rsp_sine_ff;
   assign rsp_cosine_value = rsp_cosine_ff;

   // Angle magnitude; the most negative angle maps to 2^31
   assign angle_abs = req_angle[ANGLE_W-1] ? (32'd0 - req_angle) : req_angle;

   // Halving test and reduced angle with clamp
   assign mag_ext     = CMP_W'(mag_ff);
   assign halve_limit = CMP_W'(HALF_PI_Q30) << k_ff;
   assign halve_go    = (k_ff < K_W'(MAX_HALVINGS)) && (mag_ext > halve_limit);
   assign mag_shr     = mag_ff >> k_ff;
   assign xmag_next   = (mag_shr > MAG_W'(Q30_MAX_MAG)) ? Q30_MAX_MAG : mag_shr[30:0];

   // Factorial divide: reciprocal quotient, then one-step correction
   assign tbl_idx    = 3'(term_ff);
   assign div_val    = term_divisor(cos_sel_ff, tbl_idx);
   assign prod_shr   = prod_ff >> recip_shift(cos_sel_ff, tbl_idx);
   assign q0         = prod_shr[31:0];
   assign q0_times_d = {8'd0, q0} * {32'd0, div_val};
   assign rem        = p_ff - q0_times_d[31:0];
   assign q_fix      = q0 + {31'd0, (rem >= {24'd0, div_val})};

   // Series accumulation with the current term
   assign t_val   = tneg_ff ? -$signed(ACC_W'(tmag_ff)) : $signed(ACC_W'(tmag_ff));
   assign sum_val = acc_ff + t_val;
   assign sum_sat = sat32(sum_val);

   // Double-angle operands
   assign s_abs    = s_ff[RESULT_W-1] ? (33'd0 - {s_ff[RESULT_W-1], s_ff}) : {1'b0, s_ff};
   assign c_abs    = c_ff[RESULT_W-1] ? (33'd0 - {c_ff[RESULT_W-1], c_ff}) : {1'b0, c_ff};
   assign prod_q30 = prod_ff[62:30];
   assign sc_neg   = s_ff[RESULT_W-1] ^ c_ff[RESULT_W-1];

   // Multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_SQ: begin
            mul_a = {2'b0, xmag_ff};
            mul_b = {2'b0, xmag_ff};
         end
         ST_TMUL: begin
            mul_a = {1'b0, tmag_ff};
            mul_b = {1'b0, x2_ff};
         end
         ST_TRCP: begin
            mul_a = {1'b0, prod_ff[61:30]};
            mul_b = recip_mult(cos_sel_ff, tbl_idx);
         end
         ST_DSC: begin
            mul_a = s_abs;
            mul_b = c_abs;
         end
         ST_DCC: begin
            mul_a = c_abs;
            mul_b = c_abs;
         end
         ST_DSS: begin
            mul_a = s_abs;
            mul_b = s_abs;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      k_in          = k_ff;
      xmag_in       = xmag_ff;
      x2_in         = x2_ff;
      tmag_in       = tmag_ff;
      tneg_in       = tneg_ff;
      acc_in        = acc_ff;
      term_in       = term_ff;
      cos_sel_in    = cos_sel_ff;
      p_in          = p_ff;
      s_in          = s_ff;
      c_in          = c_ff;
      sc_in         = sc_ff;
      cc_in         = cc_ff;
      rsp_sine_in   = rsp_sine_ff;
      rsp_cosine_in = rsp_cosine_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in   = req_angle[ANGLE_W-1];
               mag_in   = {angle_abs, 6'd0};
               k_in     = '0;
               state_in = ST_HALVE;
            end
         end
         ST_HALVE: begin
            if (halve_go) begin
               k_in = k_ff + K_W'(1);
            end else begin
               xmag_in  = xmag_next;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            state_in = ST_SINIT;
         end
         // x^2 lands; start the sine series at t = x
         ST_SINIT: begin
            x2_in      = prod_ff[61:30];
            tmag_in    = {1'b0, xmag_ff};
            tneg_in    = neg_ff;
            acc_in     = '0;
            term_in    = '0;
            cos_sel_in = 1'b0;
            state_in   = ST_TMUL;
         end
         // Add the current term; multiply it by x^2 unless it was the last
         ST_TMUL: begin
            acc_in = sum_val;
            if (term_ff == TERM_W'(SERIES_TERMS - 1)) begin
               if (!cos_sel_ff) begin
                  s_in       = sum_sat;
                  tmag_in    = ONE_Q30;
                  tneg_in    = 1'b0;
                  acc_in     = '0;
                  term_in    = '0;
                  cos_sel_in = 1'b1;
                  state_in   = ST_TMUL;
               end else begin
                  c_in     = sum_sat;
                  state_in = (k_ff == '0) ? ST_DONE : ST_DSC;
               end
            end else begin
               term_in  = term_ff + TERM_W'(1);
               state_in = ST_TRCP;
            end
         end
         ST_TRCP: begin
            p_in     = prod_ff[61:30];
            state_in = ST_TFIX;
         end
         // Truncated quotient becomes the next term, sign flipped
         ST_TFIX: begin
            tmag_in  = q_fix;
            tneg_in  = !tneg_ff;
            state_in = ST_TMUL;
         end
         ST_DSC: begin
            state_in = ST_DCC;
         end
         ST_DCC: begin
            sc_in    = sc_neg ? -$signed({1'b0, prod_q30}) : $signed({1'b0, prod_q30});
            state_in = ST_DSS;
         end
         ST_DSS: begin
            cc_in    = prod_q30;
            state_in = ST_DUPD;
         end
         // s' = 2sc, c' = cc - ss, both saturated
         ST_DUPD: begin
            s_in     = sat32(ACC_W'(sc_ff) <<< 1);
            c_in     = sat32($signed(ACC_W'(cc_ff)) - $signed(ACC_W'(prod_q30)));
            k_in     = k_ff - K_W'(1);
            state_in = (k_ff == K_W'(1)) ? ST_DONE : ST_DSC;
         end
         // Hand off once the output register is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_sine_in   = s_ff;
               rsp_cosine_in = c_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      k_ff          <= k_in;
      xmag_ff       <= xmag_in;
      x2_ff         <= x2_in;
      tmag_ff       <= tmag_in;
      tneg_ff       <= tneg_in;
      acc_ff        <= acc_in;
      term_ff       <= term_in;
      cos_sel_ff    <= cos_sel_in;
      p_ff          <= p_in;
      prod_ff       <= prod_in;
      s_ff          <= s_in;
      c_ff          <= c_in;
      sc_ff         <= sc_in;
      cc_ff         <= cc_in;
      rsp_sine_ff   <= rsp_sine_in;
      rsp_cosine_ff <= rsp_cosine_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/sctaylor_checker.sv
// Port-level checks for the sine/cosine Taylor core, bound to its top level.
// Depends on sctaylor_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sctaylor_checker
   import sctaylor_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic signed [ANGLE_W-1:0] req_angle,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic signed [RESULT_W-1:0] rsp_sine_value,
   input wire logic signed [RESULT_W-1:0] rsp_cosine_value
);

   // A stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sine_value)
                                  && $stable(rsp_cosine_value))
      else $error("stalled result beat changed");

   // Busy right after an angle beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready after accepting an angle");

   // A new result shows up exactly as the core returns to idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready && !$past(req_ready))
      else $error("result appeared outside the finish step");

   // Idle without a request stays idle
   assert property (@(posedge clock) disable iff (reset)
      req_ready && !req_valid |=> req_ready)
      else $error("left idle without an angle beat");

   // Reset leaves the core idle and empty
   assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind sine_cosine_taylor_halving_core sctaylor_checker u_sctaylor_checker (.*);

`default_nettype wire

>>> verif/sine_cosine_taylor_halving_core_tb.sv
// Self-checking testbench for sine_cosine_taylor_halving_core: valid/ready driver,
// monitor and an in-bench sine/cosine predictor. Depends on sctaylor_pkg and the core.
`timescale 1ns / 1ps

module sine_cosine_taylor_halving_core_tb;
   import sctaylor_pkg::*;

   // Q2.30 constants for the predictor
   localparam longint unsigned HALF_PI_MAG = 64'd1686629713;
   localparam longint          ONE_FIX     = 64'sd1073741824;
   localparam longint          FIX_MAX     = 64'sd2147483647;
   localparam longint          FIX_MIN     = -64'sd2147483648;

   // Run shape
   localparam int RANDOM_ANGLES    = 1500;
   localparam int QUIET_FIRST      = 600;
   localparam int QUIET_LAST       = 800;
   localparam int LONG_HOLD_AT     = 1000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_AT         = 500;
   localparam int SETTLE_CYCLES    = 100;

   typedef struct {
      logic signed [ANGLE_W-1:0] angle;
      int                        gap;
      bit                        drain_first;
   } angle_beat_type;

   typedef struct {
      logic signed [ANGLE_W-1:0]  angle;
      logic signed [RESULT_W-1:0] sine;
      logic signed [RESULT_W-1:0] cosine;
   } trig_pair_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [ANGLE_W-1:0]  req_angle = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [RESULT_W-1:0] rsp_sine_value;
   logic signed [RESULT_W-1:0] rsp_cosine_value;

   angle_beat_type pending_angles[$];
   trig_pair_type  expected_pairs[$];
   angle_beat_type next_beat;
   bit          next_loaded = 1'b0;
   int          gap_left = 0;
   int          angles_offered = 0;
   int          angles_accepted = 0;
   int          pairs_checked = 0;
   int          directed_count = 0;
   int          error_count = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;

   sine_cosine_taylor_halving_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_angle        (req_angle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sine_value   (rsp_sine_value),
      .rsp_cosine_value (rsp_cosine_value)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Q.30 product, magnitude truncated, 64-bit wrap on the raw product
   function automatic longint mul_q30(input longint a, input longint b);
      logic            neg;
      longint unsigned ua;
      longint unsigned ub;
      longint unsigned p;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? 64'd0 - longint'(a) : longint'(a);
      ub  = (b < 0) ? 64'd0 - longint'(b) : longint'(b);
      p   = (ua * ub) >> 30;
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint clamp_q30(input longint v);
      if (v > FIX_MAX) begin
         return FIX_MAX;
      end else if (v < FIX_MIN) begin
         return FIX_MIN;
      end
      return v;
   endfunction

   // Halve into range, sum both series, then undo the halvings by double-angle steps
   function automatic trig_pair_type predict_sine_cosine(
         input logic signed [ANGLE_W-1:0] angle);
      trig_pair_type   pair;
      logic            neg;
      longint unsigned mag;
      int              k;
      longint          x;
      longint          x2;
      longint          t;
      longint          s;
      longint          c;
      longint          ns;
      longint          nc;
      neg = angle[ANGLE_W-1];
      mag = neg ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
      mag = mag << 6;
      k = 0;
      while (k < MAX_HALVINGS && mag > (HALF_PI_MAG << k)) k++;
      mag = mag >> k;
      if (mag > longint'(FIX_MAX)) mag = FIX_MAX;
      x  = neg ? -longint'(mag) : longint'(mag);
      x2 = mul_q30(x, x);

      t = x;
      s = t;
      for (int i = 1; i < SERIES_TERMS; i++) begin
         t = -(mul_q30(t, x2) / longint'((2 * i) * (2 * i + 1)));
         s += t;
      end
      t = ONE_FIX;
      c = t;
      for (int i = 1; i < SERIES_TERMS; i++) begin
         t = -(mul_q30(t, x2) / longint'((2 * i - 1) * (2 * i)));
         c += t;
      end
      s = clamp_q30(s);
      c = clamp_q30(c);

      repeat (k) begin
         ns = clamp_q30(2 * mul_q30(s, c));
         nc = clamp_q30(mul_q30(c, c) - mul_q30(s, s));
         s  = ns;
         c  = nc;
      end
      pair.angle  = angle;
      pair.sine   = s[RESULT_W-1:0];
      pair.cosine = c[RESULT_W-1:0];
      return pair;
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return 0;
      end else if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic angle_beat_type make_beat(input logic signed [ANGLE_W-1:0] angle,
                                                input int gap, input bit drain_first);
      angle_beat_type b;
      b.angle       = angle;
      b.gap         = gap;
      b.drain_first = drain_first;
      return b;
   endfunction

   // Driver: presents the next pending angle after its gap (and drain, if asked)
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_angle <= '0;
      end else if (!req_valid || angles_accepted == angles_offered) begin
         if (!next_loaded && pending_angles.size() > 0) begin
            next_beat   = pending_angles.pop_front();
            next_loaded = 1'b1;
            gap_left    = next_beat.gap;
         end
         if (next_loaded && gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (next_loaded && next_beat.drain_first && expected_pairs.size() != 0) begin
            req_valid <= 1'b0;
         end else if (next_loaded) begin
            req_valid   <= 1'b1;
            req_angle   <= next_beat.angle;
            angles_offered++;
            next_loaded = 1'b0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, a quiet window, and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && angles_accepted >= LONG_HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (angles_accepted >= QUIET_FIRST && angles_accepted < QUIET_LAST) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left = idle_length();
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each accepted angle, check each accepted result beat
   always @(posedge clock) begin
      trig_pair_type want;
      if (!reset && req_valid && req_ready) begin
         expected_pairs.push_back(predict_sine_cosine(req_angle));
         angles_accepted <= angles_accepted + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pairs.size() == 0) begin
            $error("unexpected result beat: sine_value %0d, cosine_value %0d",
                   rsp_sine_value, rsp_cosine_value);
            error_count++;
         end else begin
            want = expected_pairs.pop_front();
            pairs_checked++;
            if (rsp_sine_value !== want.sine) begin
               $error("sine_value mismatch (angle %0d): expected %0d, actual %0d",
                      want.angle, want.sine, rsp_sine_value);
               error_count++;
            end
            if (rsp_cosine_value !== want.cosine) begin
               $error("cosine_value mismatch (angle %0d): expected %0d, actual %0d",
                      want.angle, want.cosine, rsp_cosine_value);
               error_count++;
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      logic signed [ANGLE_W-1:0] a;
      longint unsigned           edge_mag;
      int                        sel;
      int                        kk;
      int                        gap;

      // Directed: zero, unit steps, full scale, and each halving threshold
      pending_angles.push_back(make_beat(32'sd0, 0, 1'b0));
      pending_angles.push_back(make_beat(32'sd1, 0, 1'b0));
      pending_angles.push_back(make_beat(-32'sd1, 0, 1'b0));
      pending_angles.push_back(make_beat(32'sh7FFF_FFFF, 0, 1'b0));
      pending_angles.push_back(make_beat(32'sh8000_0000, 0, 1'b0));
      for (int k = 0; k < MAX_HALVINGS; k++) begin
         edge_mag = (HALF_PI_MAG << k) >> 6;
         pending_angles.push_back(make_beat(edge_mag[31:0], 0, 1'b0));
         pending_angles.push_back(make_beat(edge_mag[31:0] + 32'sd1, 0, 1'b0));
      end
      edge_mag = HALF_PI_MAG >> 6;
      pending_angles.push_back(make_beat(-(edge_mag[31:0] + 32'sd1), 0, 1'b0));
      pending_angles.push_back(make_beat(-32'sd1686629713, 0, 1'b0));
      directed_count = pending_angles.size();

      // Random: full range, small angles, halving edges and near full scale
      for (int n = 0; n < RANDOM_ANGLES; n++) begin
         sel = $urandom_range(0, 9);
         if (sel < 4) begin
            a = $urandom;
         end else if (sel < 7) begin
            a = $urandom_range(0, 32'h0FFF_FFFF) - 32'sh0800_0000;
         end else if (sel < 9) begin
            kk       = $urandom_range(0, MAX_HALVINGS - 1);
            edge_mag = (HALF_PI_MAG << kk) >> 6;
            a        = edge_mag[31:0] + $urandom_range(0, 8) - 32'sd4;
            if ($urandom_range(0, 1)) a = -a;
         end else begin
            a = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 255)
                                     : 32'sh8000_0000 + $urandom_range(0, 255);
         end
         gap = (directed_count + n >= QUIET_FIRST && directed_count + n < QUIET_LAST)
               ? 0 : idle_length();
         pending_angles.push_back(make_beat(a, gap,
            n == 0 || n == DRAIN_AT || $urandom_range(0, 99) == 0));
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for all angles accepted and all results back
      forever begin
         @(negedge clock);
         if (pending_angles.size() == 0 && !next_loaded &&
             angles_accepted == angles_offered && expected_pairs.size() == 0) break;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d angles (%0d directed, %0d random), %0d sine/cosine beats checked",
               angles_accepted, directed_count, angles_accepted - directed_count,
               pairs_checked);
      $display("covered all halving counts, full-scale angles, drains and a %0d-cycle hold-off",
               LONG_HOLD_CYCLES);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10ms;
      $error("timeout: %0d angles accepted, %0d results outstanding",
             angles_accepted, expected_pairs.size());
      $display("status: fail");
      $finish;
   end

endmodule
